### hw/rtl/perturbed_probe_hash_index_defines.svh
// Assertion macros shared by the hash index RTL.
`ifndef PERTURBED_PROBE_HASH_INDEX_DEFINES_SVH
`define PERTURBED_PROBE_HASH_INDEX_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset
`define PPI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ppi assertion failed");

// Next-cycle implication, sampled on aclk, off during reset
`define PPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ppi assertion failed");

`endif

### hw/rtl/ppi_pkg.sv
// Package: payload types, status and opcode codes, and sizing constants.
package ppi_pkg;

    localparam int DEFAULT_TABLE_DEPTH    = 1024;
    localparam int DEFAULT_MAX_CANDIDATES = 15;
    localparam int PERTURB_SHIFT          = 5;
    localparam int SIZE_LOG2_MIN          = 4;
    localparam int SIZE_LOG2_MAX          = 10;
    localparam int LIMIT_EXTRA            = 8;
    localparam int LOG2_W                 = 4;
    localparam int SLOT_W                 = 10;
    localparam int STATUS_W               = 3;

    localparam logic [LOG2_W-1:0] SIZE_LOG2_RESET = 4'd4;

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_CANDIDATE = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_END       = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [31:0] key_word;
        logic        key_last;
        logic [31:0] location;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [31:0]         location_found;
        logic [SLOT_W-1:0]   slot_index;
        logic [31:0]         key_hash;
        logic                last_result;
    } out_item_t;

    // One table row; location zero marks an empty slot
    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] location;
    } slot_entry_t;

endpackage

### hw/rtl/ppi_table.sv
// Slot table: one write port, one read port with registered read data.
module ppi_table #(
    parameter int DEPTH = ppi_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  ppi_pkg::slot_entry_t wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output ppi_pkg::slot_entry_t rd_data
);

    ppi_pkg::slot_entry_t mem [DEPTH];
    ppi_pkg::slot_entry_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/ppi_step.sv
// Probe step unit: next perturb, next slot index and step-limit check.
module ppi_step #(
    parameter int IDX_W  = $clog2(ppi_pkg::DEFAULT_TABLE_DEPTH),
    parameter int STEP_W = $clog2((1 << IDX_W) + ppi_pkg::LIMIT_EXTRA + 1)
) (
    input  logic [IDX_W-1:0]  idx,
    input  logic [31:0]       perturb,
    input  logic [IDX_W-1:0]  mask,
    input  logic [STEP_W-1:0] steps,
    input  logic [STEP_W-1:0] limit,
    output logic [IDX_W-1:0]  next_idx,
    output logic [31:0]       next_perturb,
    output logic [STEP_W-1:0] next_steps,
    output logic              limit_hit
);

    logic [IDX_W-1:0] idx_x4;
    logic [IDX_W-1:0] idx_sum;

    // perturb shifts first, then feeds the index recurrence 5*i + 1 + perturb
    assign next_perturb = perturb >> ppi_pkg::PERTURB_SHIFT;
    assign idx_x4       = {idx[IDX_W-3:0], 2'b00};
    assign idx_sum      = idx_x4 + idx + IDX_W'(1) + next_perturb[IDX_W-1:0];
    assign next_idx     = idx_sum & mask;

    // Step counter and bound
    assign next_steps = steps + STEP_W'(1);
    assign limit_hit  = (next_steps == limit);

endmodule

### hw/rtl/perturbed_probe_hash_index.sv
// Top level: key fold, probe sequencer, output register and slot table.
// Flow: a non-final key word is folded into the accumulator; after the final word the probe
// loop reads one table slot per step, and the last result is loaded into the output register.
// Throughput: one key at a time; the next word is taken once the probe ends and the last result
// is loaded, later while a result waits. Reset: synchronous active-low aresetn, then a clearing
// pass zeroes every slot with s_ready low; config lands.
module perturbed_probe_hash_index #(
    parameter int TABLE_DEPTH    = ppi_pkg::DEFAULT_TABLE_DEPTH,
    parameter int MAX_CANDIDATES = ppi_pkg::DEFAULT_MAX_CANDIDATES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ppi_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ppi_pkg::out_item_t           m_data,
    input  logic                         cfg_wr_en,
    input  logic [ppi_pkg::LOG2_W-1:0]   cfg_wr_data
);

`include "perturbed_probe_hash_index_defines.svh"

    localparam int IDX_W      = $clog2(TABLE_DEPTH);
    localparam int MAX_LOG2   = (IDX_W < ppi_pkg::SIZE_LOG2_MAX) ? IDX_W
                                                                 : ppi_pkg::SIZE_LOG2_MAX;
    localparam int USE_DEPTH  = 1 << MAX_LOG2;
    localparam int STEP_W     = $clog2(USE_DEPTH + ppi_pkg::LIMIT_EXTRA + 1);
    localparam int CAND_W     = $clog2(MAX_CANDIDATES + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t                          state_reg;
    logic [ppi_pkg::LOG2_W-1:0]      cfg_log2_reg;
    logic [IDX_W-1:0]                clr_reg;
    logic [31:0]                     acc_reg;
    logic                            pend_op_reg;
    logic                            in_key_reg;
    logic [31:0]                     hash_reg;
    logic                            op_reg;
    logic [31:0]                     loc_reg;
    logic [31:0]                     perturb_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic [STEP_W-1:0]               steps_reg;
    logic [CAND_W-1:0]               cand_reg;
    logic [ppi_pkg::STATUS_W-1:0]    fin_status_reg;
    logic [IDX_W-1:0]                fin_slot_reg;
    logic                            m_valid_reg;
    ppi_pkg::out_item_t              m_data_reg;

    logic [ppi_pkg::LOG2_W-1:0]      log2_eff;
    logic [IDX_W-1:0]                mask;
    logic [STEP_W-1:0]               limit;
    logic                            in_xfer;
    logic [31:0]                     word_hash;
    logic                            word_op;
    logic [IDX_W-1:0]                start_idx;
    logic                            start_reject;
    logic                            start_read;
    logic                            out_free;
    logic                            is_insert;
    logic                            slot_empty;
    logic                            slot_match;
    logic                            cand_full;
    logic                            chk_write;
    logic                            chk_adv;
    logic                            cand_load;
    logic                            fin_load;
    logic                            out_load;
    logic [IDX_W-1:0]                next_idx;
    logic [31:0]                     next_perturb;
    logic [STEP_W-1:0]               next_steps;
    logic                            limit_hit;
    logic                            tbl_we;
    logic [IDX_W-1:0]                tbl_waddr;
    ppi_pkg::slot_entry_t            tbl_wdata;
    logic                            tbl_re;
    logic [IDX_W-1:0]                tbl_raddr;
    ppi_pkg::slot_entry_t            tbl_rdata;

    // Table size: clamp the register to the supported range
    always_comb begin
        priority if (cfg_log2_reg < ppi_pkg::LOG2_W'(ppi_pkg::SIZE_LOG2_MIN)) begin
            log2_eff = ppi_pkg::LOG2_W'(ppi_pkg::SIZE_LOG2_MIN);
        end else if (cfg_log2_reg > ppi_pkg::LOG2_W'(MAX_LOG2)) begin
            log2_eff = ppi_pkg::LOG2_W'(MAX_LOG2);
        end else begin
            log2_eff = cfg_log2_reg;
        end
    end

    assign mask  = ~({IDX_W{1'b1}} << log2_eff);
    assign limit = STEP_W'(mask) + STEP_W'(ppi_pkg::LIMIT_EXTRA + 1);

    // Input side: fold the word, start a probe on the final word
    assign s_ready      = (state_reg == ST_IDLE);
    assign in_xfer      = s_valid && s_ready;
    assign word_hash    = acc_reg ^ s_data.key_word;
    assign word_op      = in_key_reg ? pend_op_reg : s_data.opcode;
    assign start_idx    = word_hash[IDX_W-1:0] & mask;
    assign start_reject = (word_op == ppi_pkg::OP_INSERT) && (s_data.location == '0);
    assign start_read   = in_xfer && s_data.key_last && !start_reject;

    // Probe decisions on the slot just read
    assign out_free   = !m_valid_reg || m_ready;
    assign is_insert  = (op_reg == ppi_pkg::OP_INSERT);
    assign slot_empty = (tbl_rdata.location == '0);
    assign slot_match = (tbl_rdata.hash == hash_reg);
    assign cand_full  = (cand_reg == CAND_W'(MAX_CANDIDATES));
    assign chk_write  = (state_reg == ST_CHECK) && is_insert && slot_empty;
    assign cand_load  = (state_reg == ST_CHECK) && !is_insert && !slot_empty && slot_match
                        && !cand_full && out_free;
    assign chk_adv    = (state_reg == ST_CHECK) && !slot_empty
                        && (is_insert || !slot_match || (!cand_full && out_free));
    assign fin_load   = (state_reg == ST_FINISH) && out_free;
    assign out_load   = cand_load || fin_load;

    // Shared step unit
    ppi_step #(
        .IDX_W  (IDX_W),
        .STEP_W (STEP_W)
    ) u_step (
        .idx          (idx_reg),
        .perturb      (perturb_reg),
        .mask         (mask),
        .steps        (steps_reg),
        .limit        (limit),
        .next_idx     (next_idx),
        .next_perturb (next_perturb),
        .next_steps   (next_steps),
        .limit_hit    (limit_hit)
    );

    // Table ports: clearing sweep, insert write, probe reads
    assign tbl_we    = (state_reg == ST_CLEAR) || chk_write;
    assign tbl_waddr = (state_reg == ST_CLEAR) ? clr_reg : idx_reg;
    assign tbl_wdata = (state_reg == ST_CLEAR) ? '0 : {hash_reg, loc_reg};
    assign tbl_re    = start_read || (chk_adv && !limit_hit);
    assign tbl_raddr = (state_reg == ST_CHECK) ? next_idx : start_idx;

    ppi_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_en   (tbl_re),
        .rd_addr (tbl_raddr),
        .rd_data (tbl_rdata)
    );

    // Sequencer, config register and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            cfg_log2_reg <= ppi_pkg::SIZE_LOG2_RESET;
            acc_reg      <= '0;
            pend_op_reg  <= 1'b0;
            in_key_reg   <= 1'b0;
            cand_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_log2_reg <= cfg_wr_data;
            end

            // Output register: load, or drain on a transfer
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cand_load) begin
                m_data_reg.status         <= ppi_pkg::STATUS_CANDIDATE;
                m_data_reg.location_found <= tbl_rdata.location;
                m_data_reg.slot_index     <= ppi_pkg::SLOT_W'(idx_reg);
                m_data_reg.key_hash       <= hash_reg;
                m_data_reg.last_result    <= 1'b0;
            end else if (fin_load) begin
                m_data_reg.status         <= fin_status_reg;
                m_data_reg.location_found <= '0;
                m_data_reg.slot_index     <= ppi_pkg::SLOT_W'(fin_slot_reg);
                m_data_reg.key_hash       <= hash_reg;
                m_data_reg.last_result    <= 1'b1;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == {IDX_W{1'b1}}) begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    if (in_xfer) begin
                        if (!s_data.key_last) begin
                            acc_reg     <= word_hash;
                            pend_op_reg <= word_op;
                            in_key_reg  <= 1'b1;
                        end else begin
                            acc_reg     <= '0;
                            pend_op_reg <= 1'b0;
                            in_key_reg  <= 1'b0;
                            hash_reg    <= word_hash;
                            op_reg      <= word_op;
                            loc_reg     <= s_data.location;
                            perturb_reg <= word_hash;
                            idx_reg     <= start_idx;
                            steps_reg   <= '0;
                            cand_reg    <= '0;
                            if (start_reject) begin
                                fin_status_reg <= ppi_pkg::STATUS_FULL;
                                fin_slot_reg   <= '0;
                                state_reg      <= ST_FINISH;
                            end else begin
                                state_reg <= ST_CHECK;
                            end
                        end
                    end
                end

                ST_CHECK: begin
                    priority if (chk_write) begin
                        fin_status_reg <= ppi_pkg::STATUS_INSERTED;
                        fin_slot_reg   <= idx_reg;
                        state_reg      <= ST_FINISH;
                    end else if (!is_insert && slot_empty) begin
                        fin_status_reg <= ppi_pkg::STATUS_END;
                        fin_slot_reg   <= '0;
                        state_reg      <= ST_FINISH;
                    end else if (!is_insert && slot_match && cand_full) begin
                        fin_status_reg <= ppi_pkg::STATUS_OVERFLOW;
                        fin_slot_reg   <= '0;
                        state_reg      <= ST_FINISH;
                    end else if (chk_adv) begin
                        if (cand_load) begin
                            cand_reg <= cand_reg + CAND_W'(1);
                        end
                        if (limit_hit) begin
                            fin_status_reg <= is_insert ? ppi_pkg::STATUS_FULL
                                                        : ppi_pkg::STATUS_END;
                            fin_slot_reg   <= '0;
                            state_reg      <= ST_FINISH;
                        end else begin
                            idx_reg     <= next_idx;
                            perturb_reg <= next_perturb;
                            steps_reg   <= next_steps;
                        end
                    end else begin
                        // candidate waits for the output register
                        state_reg <= ST_CHECK;
                    end
                end

                ST_FINISH: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks on the sequencer
    `PPI_ASSERT_NOW(a_cand_bound, 1'b1, cand_reg <= CAND_W'(MAX_CANDIDATES))
    `PPI_ASSERT_NOW(a_step_bound, state_reg == ST_CHECK, steps_reg < limit)
    `PPI_ASSERT_NOW(a_clear_quiet, state_reg == ST_CLEAR, !m_valid_reg && !s_ready)
    `PPI_ASSERT_NOW(a_insert_store, tbl_we && state_reg != ST_CLEAR, is_insert && loc_reg != '0)

endmodule

### tb/testbench.sv
// Self-checking testbench for the perturbed-probe hash index: directed table, then random keys.
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 20000;
    localparam int TBL_DEPTH   = ppi_pkg::DEFAULT_TABLE_DEPTH;
    localparam int PHASE_WORDS = 55;
    localparam int SETTLE      = 8;

    // Directed row: a word repeated reps times (location bumped per repeat),
    // optionally with a hand-written single result
    typedef struct packed {
        logic [7:0]         reps;
        ppi_pkg::in_item_t  word;
        logic               typed;
        ppi_pkg::out_item_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 13;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // lookup on the empty table
        '{8'd1, '{ppi_pkg::OP_LOOKUP, 32'h0000_0013, 1'b1, 32'h0},
          1'b1, '{ppi_pkg::STATUS_END, 32'h0, 10'd0, 32'h0000_0013, 1'b1}},
        // first insert lands on its home slot
        '{8'd1, '{ppi_pkg::OP_INSERT, 32'h0000_0013, 1'b1, 32'hFFFF_FFFF},
          1'b1, '{ppi_pkg::STATUS_INSERTED, 32'h0, 10'd3, 32'h0000_0013, 1'b1}},
        // insert with a zero location is rejected
        '{8'd1, '{ppi_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h0},
          1'b1, '{ppi_pkg::STATUS_FULL, 32'h0, 10'd0, 32'hFFFF_FFFF, 1'b1}},
        '{8'd1, '{ppi_pkg::OP_LOOKUP, 32'h0000_0013, 1'b1, 32'h0}, 1'b0, '0},
        // two-word insert; opcode on the last word is ignored
        '{8'd1, '{ppi_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF}, 1'b0, '0},
        '{8'd1, '{ppi_pkg::OP_LOOKUP, 32'hFFFF_FFEC, 1'b1, 32'h0000_0001}, 1'b0, '0},
        // three-word insert folding to the same hash
        '{8'd1, '{ppi_pkg::OP_INSERT, 32'h8000_0000, 1'b0, 32'h0}, 1'b0, '0},
        '{8'd1, '{ppi_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 1'b0, 32'h0}, 1'b0, '0},
        '{8'd1, '{ppi_pkg::OP_INSERT, 32'hFFFF_FFEC, 1'b1, 32'h8000_0000}, 1'b0, '0},
        // fill the rest of the 16-slot table with the same hash
        '{8'd13, '{ppi_pkg::OP_INSERT, 32'h0000_0013, 1'b1, 32'h0001_0000}, 1'b0, '0},
        // no empty slot left
        '{8'd1, '{ppi_pkg::OP_INSERT, 32'h0000_0013, 1'b1, 32'h5A5A_5A5A},
          1'b1, '{ppi_pkg::STATUS_FULL, 32'h0, 10'd0, 32'h0000_0013, 1'b1}},
        // sixteen matches: candidate cap overflows
        '{8'd1, '{ppi_pkg::OP_LOOKUP, 32'h0000_0013, 1'b1, 32'h0}, 1'b0, '0},
        // full table, no match: walk to the step bound
        '{8'd1, '{ppi_pkg::OP_LOOKUP, 32'h0000_0005, 1'b1, 32'h0}, 1'b0, '0}
    };

    localparam logic [ppi_pkg::LOG2_W-1:0] PHASE_SIZES [6] =
        '{4'd10, 4'd15, 4'd7, 4'd5, 4'd12, 4'd3};

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    ppi_pkg::in_item_t            s_data      = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    ppi_pkg::out_item_t           m_data;
    logic                         cfg_wr_en   = 1'b0;
    logic [ppi_pkg::LOG2_W-1:0]   cfg_wr_data = '0;

    // Shadow of the index
    logic [31:0]                stored_hash [TBL_DEPTH] = '{default: '0};
    logic [31:0]                stored_loc  [TBL_DEPTH] = '{default: '0};
    logic [31:0]                fold_acc    = '0;
    logic                       open_op     = ppi_pkg::OP_INSERT;
    logic                       key_open    = 1'b0;
    logic [ppi_pkg::LOG2_W-1:0] size_sel    = ppi_pkg::SIZE_LOG2_RESET;

    ppi_pkg::out_item_t probe_results_due [$];
    logic [31:0]        inserted_hashes [$];
    ppi_pkg::out_item_t next_want;

    int src_idle_pct  = 7;
    int sink_idle_pct = 55;
    int words_sent    = 0;
    int mismatches    = 0;
    int stall_count   = 0;

    perturbed_probe_hash_index u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Fold one key word; on the last word probe the shadow table and queue the results
    function automatic void probe_index(input ppi_pkg::in_item_t w);
        logic               op;
        logic [31:0]        h;
        logic [31:0]        perturb;
        int unsigned        n_log2, mask, idx, steps, limit, found;
        ppi_pkg::out_item_t r;
        op = key_open ? open_op : w.opcode;
        h  = fold_acc ^ w.key_word;
        if (!w.key_last) begin
            fold_acc = h;
            open_op  = op;
            key_open = 1'b1;
            return;
        end
        fold_acc = '0;
        open_op  = ppi_pkg::OP_INSERT;
        key_open = 1'b0;

        n_log2 = size_sel;
        if (n_log2 < ppi_pkg::SIZE_LOG2_MIN) n_log2 = ppi_pkg::SIZE_LOG2_MIN;
        if (n_log2 > ppi_pkg::SIZE_LOG2_MAX) n_log2 = ppi_pkg::SIZE_LOG2_MAX;
        mask    = (1 << n_log2) - 1;
        limit   = mask + 1 + ppi_pkg::LIMIT_EXTRA;
        perturb = h;
        idx     = h & mask;
        r = '0;
        r.key_hash    = h;
        r.last_result = 1'b1;

        if (op == ppi_pkg::OP_INSERT) begin
            r.status = ppi_pkg::STATUS_FULL;
            if (w.location != 0) begin
                for (steps = 0; steps < limit; steps++) begin
                    if (stored_loc[idx] == 0) begin
                        stored_hash[idx] = h;
                        stored_loc[idx]  = w.location;
                        r.status     = ppi_pkg::STATUS_INSERTED;
                        r.slot_index = idx[ppi_pkg::SLOT_W-1:0];
                        break;
                    end
                    perturb = perturb >> ppi_pkg::PERTURB_SHIFT;
                    idx = (idx * 5 + 1 + perturb) & mask;
                end
            end
            probe_results_due.push_back(r);
            return;
        end

        // Lookup: report matches until an empty slot or the step bound
        found = 0;
        for (steps = 0; steps < limit; steps++) begin
            if (stored_loc[idx] == 0) break;
            if (stored_hash[idx] == h) begin
                if (found >= ppi_pkg::DEFAULT_MAX_CANDIDATES) begin
                    r.status = ppi_pkg::STATUS_OVERFLOW;
                    probe_results_due.push_back(r);
                    return;
                end
                probe_results_due.push_back(ppi_pkg::out_item_t'{
                    ppi_pkg::STATUS_CANDIDATE, stored_loc[idx],
                    idx[ppi_pkg::SLOT_W-1:0], h, 1'b0});
                found++;
            end
            perturb = perturb >> ppi_pkg::PERTURB_SHIFT;
            idx = (idx * 5 + 1 + perturb) & mask;
        end
        r.status = ppi_pkg::STATUS_END;
        probe_results_due.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    endtask

    // One word transfer on the input channel, with random idle cycles ahead of it
    task automatic send_word(input ppi_pkg::in_item_t w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        probe_index(w);
    endtask

    // Split a hash into nwords random words that fold back to it
    task automatic send_key(input logic op, input logic [31:0] h, input int nwords,
                            input logic [31:0] loc);
        ppi_pkg::in_item_t w;
        logic [31:0]       acc;
        int                i;
        acc = '0;
        for (i = 0; i < nwords; i++) begin
            w.opcode   = (i == 0) ? op : logic'($urandom_range(1));
            w.key_last = (i == nwords - 1);
            w.key_word = w.key_last ? (h ^ acc) : $urandom;
            w.location = w.key_last ? loc : $urandom;
            acc ^= w.key_word;
            send_word(w);
        end
    endtask

    // Hold off the sender until every queued result has been checked
    task automatic wait_idle(input int settle);
        s_valid <= 1'b0;
        do @(posedge aclk); while (probe_results_due.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_table_size(input logic [ppi_pkg::LOG2_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        size_sel     = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_hash(input int reuse_pct);
        if (inserted_hashes.size() != 0 && $urandom_range(99) < reuse_pct)
            return inserted_hashes[$urandom_range(inserted_hashes.size() - 1)];
        return $urandom;
    endfunction

    // Result channel: random stall, check, and the no-progress watchdog
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (probe_results_due.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(m_data.status), '0);
            end else begin
                next_want = probe_results_due.pop_front();
                if (m_data.status !== next_want.status)
                    report_mismatch("status", 32'(m_data.status), 32'(next_want.status));
                if (m_data.location_found !== next_want.location_found)
                    report_mismatch("location_found", m_data.location_found,
                                    next_want.location_found);
                if (m_data.slot_index !== next_want.slot_index)
                    report_mismatch("slot_index", 32'(m_data.slot_index),
                                    32'(next_want.slot_index));
                if (m_data.key_hash !== next_want.key_hash)
                    report_mismatch("key_hash", m_data.key_hash, next_want.key_hash);
                if (m_data.last_result !== next_want.last_result)
                    report_mismatch("last_result", 32'(m_data.last_result),
                                    32'(next_want.last_result));
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_count = 0;
        else stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        ppi_pkg::in_item_t w;
        dir_row_t          row;
        int                r, k, p, pick, nwords, phase_end;
        logic [31:0]       h, loc;

        inserted_hashes.push_back(32'h0000_0013);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // lands during the clearing pass; below 4 acts as 16 slots
        set_table_size(4'd0);

        // Directed table
        for (r = 0; r < DIR_ROWS; r++) begin
            row = DIRECTED[r];
            for (k = 0; k < row.reps; k++) begin
                w = row.word;
                w.location = row.word.location + k;
                send_word(w);
                if (row.typed) probe_results_due[probe_results_due.size() - 1] = row.want;
            end
        end

        // Random keys, one table size per phase
        for (p = 0; p < 6; p++) begin
            wait_idle(SETTLE);
            src_idle_pct  = (p < 2) ? 7 : (p < 4) ? 55 : 0;
            sink_idle_pct = (p < 2) ? 55 : (p < 4) ? 7 : 0;
            set_table_size(PHASE_SIZES[p]);
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                pick   = $urandom_range(99);
                nwords = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 4);
                if (pick < 4) wait_idle(0);
                if (pick < 12) begin
                    // stray word, may open or close a key
                    w.opcode   = 1'($urandom_range(1));
                    w.key_word = $urandom;
                    w.key_last = 1'($urandom_range(1));
                    w.location = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
                    send_word(w);
                end else if (pick < 17) begin
                    send_key(ppi_pkg::OP_INSERT, pick_hash(50), nwords, 32'h0);
                end else if (pick < 57) begin
                    h   = pick_hash(50);
                    loc = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
                    if (loc == 0) loc = 32'h1;
                    send_key(ppi_pkg::OP_INSERT, h, nwords, loc);
                    inserted_hashes.push_back(h);
                end else begin
                    send_key(ppi_pkg::OP_LOOKUP, pick_hash(75), nwords, $urandom);
                end
            end
            // close any key left open by a stray word
            send_key(ppi_pkg::OP_LOOKUP, pick_hash(75), 1, 32'h0);
        end

        wait_idle(20);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
